// ===== src/assert_macros.svh =====
// Assertion helpers shared by the RTL files.
// Both macros sample on the rising edge of clock and stay quiet during reset.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property that holds at every sampled edge
`define ASSERT_ALWAYS(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (prop)) else $error(msg);

// Consequent that must hold in the cycle where the antecedent holds
`define ASSERT_IMPLIES(label, pre, post, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (pre) |-> (post)) else $error(msg);

`endif

// ===== src/mbt_pkg.sv =====
package mbt_pkg;

   // fixed-point format of c and z
   localparam int FRAC_BITS = 28;

   // input field widths
   localparam int C_W     = 32;
   localparam int LIMIT_W = 17;

   // stream payload widths, padded to whole bytes
   localparam int REQ_DATA_W = ((2 * C_W + LIMIT_W + 7) / 8) * 8;
   localparam int RSP_DATA_W = 8;

   // multiplier operand: |z| < 2 needs FRAC_BITS + 1 magnitude bits plus sign
   localparam int MUL_W  = FRAC_BITS + 3;
   localparam int PROD_W = 2 * MUL_W;

   // z register: holds a new component up to |c| + 4 without wrapping
   localparam int ZW = ((MUL_W > C_W) ? MUL_W : C_W) + 2;

   // escape bounds
   localparam logic signed [ZW-1:0]   TWO  = ZW'(2) <<< FRAC_BITS;
   localparam logic signed [ZW-1:0]   NEG_TWO = -TWO;
   localparam logic        [PROD_W:0] FOUR = (PROD_W + 1)'(1) << (2 * FRAC_BITS + 2);

   // queue between front and back
   localparam int Q_DEPTH = 2;
   localparam int Q_PTR_W = (Q_DEPTH > 1) ? $clog2(Q_DEPTH) : 1;
   localparam int Q_CNT_W = $clog2(Q_DEPTH + 1);

   // one classified point waiting for the iteration engine
   typedef struct packed {
      logic signed [C_W-1:0]  c_real;
      logic signed [C_W-1:0]  c_imag;
      logic [LIMIT_W-1:0]     iteration_limit;
      logic                   zero_limit;
   } point_type;

endpackage

// ===== src/mbt_front.sv =====
`include "assert_macros.svh"

module mbt_front (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_tvalid,
   output logic                           req_tready,
   // c_real [31:0], c_imag [63:32], iteration_limit [80:64], zero pad above
   input  logic [mbt_pkg::REQ_DATA_W-1:0] req_tdata,
   output logic                           head_valid,
   output mbt_pkg::point_type             head,
   input  logic                           head_pop
);
   import mbt_pkg::*;

   point_type              slot_ff [Q_DEPTH];
   logic [Q_PTR_W-1:0]     wr_ptr_ff, wr_ptr_in;
   logic [Q_PTR_W-1:0]     rd_ptr_ff, rd_ptr_in;
   logic [Q_CNT_W-1:0]     count_ff, count_in;
   point_type              incoming;
   logic                   push;

   // classify the incoming point
   always_comb begin
      incoming.c_real          = $signed(req_tdata[C_W-1:0]);
      incoming.c_imag          = $signed(req_tdata[2*C_W-1:C_W]);
      incoming.iteration_limit = req_tdata[2*C_W+LIMIT_W-1:2*C_W];
      incoming.zero_limit      = (req_tdata[2*C_W+LIMIT_W-1:2*C_W] == '0);
   end

   assign req_tready = (count_ff != Q_CNT_W'(Q_DEPTH));
   assign push       = req_tvalid && req_tready;
   assign head_valid = (count_ff != '0);
   assign head       = slot_ff[rd_ptr_ff];

   // advance pointers and fill level
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == Q_PTR_W'(Q_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (head_pop) begin
         rd_ptr_in = (rd_ptr_ff == Q_PTR_W'(Q_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !head_pop) begin
         count_in = count_ff + 1'b1;
      end else if (!push && head_pop) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // store the transfer in its slot
   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= incoming;
      end
   end

   `ASSERT_IMPLIES(a_pop_nonempty, head_pop, count_ff != '0, "pop from an empty queue")
   `ASSERT_ALWAYS(a_count_bound, count_ff <= Q_CNT_W'(Q_DEPTH), "queue fill level overrun")

endmodule

// ===== src/mbt_engine.sv =====
`include "assert_macros.svh"

module mbt_engine (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           head_valid,
   input  mbt_pkg::point_type             head,
   output logic                           head_pop,
   output logic                           rsp_tvalid,
   input  logic                           rsp_tready,
   // in_set [0], zero pad above
   output logic [mbt_pkg::RSP_DATA_W-1:0] rsp_tdata
);
   import mbt_pkg::*;

   typedef enum logic [3:0] {
      ST_IDLE = 4'b0001,
      ST_MUL  = 4'b0010,
      ST_ADD  = 4'b0100,
      ST_HOLD = 4'b1000
   } state_type;

   state_type               state_ff, state_in;
   logic signed [ZW-1:0]    re_ff, re_in;
   logic signed [ZW-1:0]    im_ff, im_in;
   logic signed [ZW-1:0]    cr_ff, cr_in;
   logic signed [ZW-1:0]    ci_ff, ci_in;
   logic [LIMIT_W-1:0]      limit_ff, limit_in;
   logic [LIMIT_W-1:0]      count_ff, count_in;
   logic signed [PROD_W-1:0] prr_ff, pii_ff, pri_ff;
   logic                    result_ff, result_in;
   logic                    rsp_valid_ff, rsp_valid_in;
   logic                    in_set_ff, in_set_in;

   logic signed [MUL_W-1:0] mre, mim;
   logic                    mag_escape;
   logic [PROD_W:0]         sum_sq;
   logic signed [PROD_W:0]  diff, diff_sh;
   logic signed [PROD_W-1:0] cross_sh;
   logic signed [ZW-1:0]    nre, nim;
   logic                    out_free;
   logic                    finish;
   logic                    finish_bit;

   // multiplier operands: valid whenever the magnitude check passes
   assign mre = $signed(re_ff[MUL_W-1:0]);
   assign mim = $signed(im_ff[MUL_W-1:0]);

   assign mag_escape = (re_ff >= TWO) || (re_ff <= NEG_TWO) ||
                       (im_ff >= TWO) || (im_ff <= NEG_TWO);

   // squared magnitude and next z from the registered products
   assign sum_sq   = {1'b0, prr_ff} + {1'b0, pii_ff};
   assign diff     = $signed({prr_ff[PROD_W-1], prr_ff}) - $signed({pii_ff[PROD_W-1], pii_ff});
   assign diff_sh  = diff >>> FRAC_BITS;
   assign cross_sh = pri_ff >>> (FRAC_BITS - 1);
   assign nre      = $signed(diff_sh[ZW-1:0]) + cr_ff;
   assign nim      = $signed(cross_sh[ZW-1:0]) + ci_ff;

   assign out_free = !rsp_valid_ff || rsp_tready;

   // sequence one point through the multiply / add loop
   always_comb begin
      state_in   = state_ff;
      re_in      = re_ff;
      im_in      = im_ff;
      cr_in      = cr_ff;
      ci_in      = ci_ff;
      limit_in   = limit_ff;
      count_in   = count_ff;
      result_in  = result_ff;
      head_pop   = 1'b0;
      finish     = 1'b0;
      finish_bit = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            if (head_valid) begin
               head_pop = 1'b1;
               cr_in    = ZW'(head.c_real);
               ci_in    = ZW'(head.c_imag);
               limit_in = head.iteration_limit;
               count_in = '0;
               re_in    = '0;
               im_in    = '0;
               if (head.zero_limit) begin
                  finish     = 1'b1;
                  finish_bit = 1'b1;
               end else begin
                  state_in = ST_MUL;
               end
            end
         end
         ST_MUL: begin
            if (mag_escape) begin
               finish     = 1'b1;
               finish_bit = 1'b0;
            end else begin
               state_in = ST_ADD;
            end
         end
         ST_ADD: begin
            if (sum_sq >= FOUR) begin
               finish     = 1'b1;
               finish_bit = 1'b0;
            end else if (count_ff == limit_ff) begin
               finish     = 1'b1;
               finish_bit = 1'b1;
            end else begin
               re_in    = nre;
               im_in    = nim;
               count_in = count_ff + 1'b1;
               state_in = ST_MUL;
            end
         end
         ST_HOLD: begin
            if (out_free) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
      // park the result until the output register frees up
      if (finish) begin
         result_in = finish_bit;
         state_in  = out_free ? ST_IDLE : ST_HOLD;
      end
   end

   // output register
   always_comb begin
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      in_set_in    = in_set_ff;
      if (finish && out_free) begin
         rsp_valid_in = 1'b1;
         in_set_in    = finish_bit;
      end else if (state_ff == ST_HOLD && out_free) begin
         rsp_valid_in = 1'b1;
         in_set_in    = result_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // datapath registers
   always_ff @(posedge clock) begin
      re_ff     <= re_in;
      im_ff     <= im_in;
      cr_ff     <= cr_in;
      ci_ff     <= ci_in;
      limit_ff  <= limit_in;
      count_ff  <= count_in;
      result_ff <= result_in;
      in_set_ff <= in_set_in;
      prr_ff    <= mre * mre;
      pii_ff    <= mim * mim;
      pri_ff    <= mre * mim;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {{(RSP_DATA_W - 1){1'b0}}, in_set_ff};

   `ASSERT_IMPLIES(a_add_after_mul, state_ff == ST_ADD, $past(state_ff == ST_MUL),
      "add step without a multiply step before it")
   `ASSERT_IMPLIES(a_count_in_limit, (state_ff == ST_MUL) || (state_ff == ST_ADD),
      count_ff <= limit_ff, "iteration count beyond the limit")

endmodule

// ===== src/mandelbrot_escape_test.sv =====
// Path from input transfer to result valid: a queue slot, then the engine, which settles a zero
// limit in its idle state and otherwise iterates until a component of z reaches 2, |z|^2 reaches
// 4 or the limit is met, then the output register. The engine handles one point at a time, with
// a multiply step and an add step per iteration, and starts the next once its result is registered.
// A two-entry queue takes new points while the engine works and a result waits.
// Reset is synchronous and active high; it empties the queue and drops any pending result.
module mandelbrot_escape_test (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_tvalid,
   output logic                           req_tready,
   // c_real [31:0], c_imag [63:32], iteration_limit [80:64], zero pad above
   input  logic [mbt_pkg::REQ_DATA_W-1:0] req_tdata,
   output logic                           rsp_tvalid,
   input  logic                           rsp_tready,
   // in_set [0], zero pad above
   output logic [mbt_pkg::RSP_DATA_W-1:0] rsp_tdata
);
   import mbt_pkg::*;

   logic      head_valid;
   point_type head;
   logic      head_pop;

   // accept and classify points, queue them
   mbt_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .head_valid (head_valid),
      .head       (head),
      .head_pop   (head_pop)
   );

   // iterate each point and deliver the verdict
   mbt_engine u_engine (
      .clock      (clock),
      .reset      (reset),
      .head_valid (head_valid),
      .head       (head),
      .head_pop   (head_pop),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

endmodule

// ===== test/mandelbrot_escape_test_checker.sv =====
`timescale 1ns / 1ps

module mandelbrot_escape_test_checker (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_tvalid,
   input  logic                           req_tready,
   // c_real [31:0], c_imag [63:32], iteration_limit [80:64], zero pad above
   input  logic [mbt_pkg::REQ_DATA_W-1:0] req_tdata,
   input  logic                           rsp_tvalid,
   input  logic                           rsp_tready,
   // in_set [0], zero pad above
   input  logic [mbt_pkg::RSP_DATA_W-1:0] rsp_tdata,
   output int                             failures,
   output int                             verdicts_pending,
   output int                             points_checked,
   output int                             inside_count
);

   localparam int FB  = mbt_pkg::FRAC_BITS;
   localparam int CW  = mbt_pkg::C_W;
   localparam int LW  = mbt_pkg::LIMIT_W;
   localparam int MAX_REPORTS = 10;

   typedef struct {
      logic signed [CW-1:0] c_real;
      logic signed [CW-1:0] c_imag;
      logic [LW-1:0]        limit;
      logic                 in_set;
   } orbit_verdict_t;

   orbit_verdict_t verdicts_due[$];
   orbit_verdict_t arrived_point;
   orbit_verdict_t new_point;
   int             fail_total = 0;
   int             checked_total = 0;
   int             inside_total = 0;

   // Iterate z <- z*z + c from zero; 1 if no escape within the limit
   function automatic logic bounded_orbit(input logic signed [CW-1:0] c_re,
                                          input logic signed [CW-1:0] c_im,
                                          input logic [LW-1:0]        limit);
      logic signed [63:0]  z_re;
      logic signed [63:0]  z_im;
      logic signed [63:0]  c_re_w;
      logic signed [63:0]  c_im_w;
      logic signed [63:0]  two_w;
      logic signed [127:0] wide_re;
      logic signed [127:0] wide_im;
      logic signed [127:0] square_diff;
      logic signed [127:0] cross_term;
      logic signed [127:0] magnitude_sq;
      logic signed [127:0] four_w;
      int unsigned         step;
      z_re   = '0;
      z_im   = '0;
      c_re_w = 64'(c_re);
      c_im_w = 64'(c_im);
      two_w  = 64'sd1 <<< (FB + 1);
      four_w = 128'sd1 <<< (2 * FB + 2);
      for (step = 0; step < limit; step++) begin
         wide_re     = 128'(z_re);
         wide_im     = 128'(z_im);
         // floor of the scaled products, i.e. arithmetic shifts
         square_diff = (wide_re * wide_re - wide_im * wide_im) >>> FB;
         cross_term  = (wide_re * wide_im) >>> (FB - 1);
         z_re        = square_diff[63:0] + c_re_w;
         z_im        = cross_term[63:0] + c_im_w;
         // a component at 2 or beyond has escaped
         if (z_re >= two_w || z_re <= -two_w || z_im >= two_w || z_im <= -two_w)
            return 1'b0;
         wide_re      = 128'(z_re);
         wide_im      = 128'(z_im);
         magnitude_sq = wide_re * wide_re + wide_im * wide_im;
         if (magnitude_sq >= four_w)
            return 1'b0;
      end
      return 1'b1;
   endfunction

   task automatic note_failure(input string what);
      if (fail_total < MAX_REPORTS)
         $display("%0t: %s", $realtime, what);
      fail_total++;
   endtask

   always @(posedge clock) begin
      if (!reset) begin
         // retire the oldest outstanding point on each result transfer
         if (rsp_tvalid && rsp_tready) begin
            if (verdicts_due.size() == 0) begin
               note_failure($sformatf("result in_set=%0b with no point outstanding",
                                      rsp_tdata[0]));
            end else begin
               arrived_point = verdicts_due.pop_front();
               checked_total++;
               if (arrived_point.in_set)
                  inside_total++;
               if (rsp_tdata[0] !== arrived_point.in_set)
                  note_failure($sformatf(
                     "in_set mismatch c=(%0d, %0d) limit=%0d: expected %0b, got %0b",
                     arrived_point.c_real, arrived_point.c_imag, arrived_point.limit,
                     arrived_point.in_set, rsp_tdata[0]));
            end
         end
         // predict the verdict of each point transfer
         if (req_tvalid && req_tready) begin
            new_point.c_real = req_tdata[CW-1:0];
            new_point.c_imag = req_tdata[2*CW-1:CW];
            new_point.limit  = req_tdata[2*CW+LW-1:2*CW];
            new_point.in_set = bounded_orbit(new_point.c_real, new_point.c_imag,
                                             new_point.limit);
            verdicts_due.push_back(new_point);
         end
      end
      failures         <= fail_total;
      verdicts_pending <= verdicts_due.size();
      points_checked   <= checked_total;
      inside_count     <= inside_total;
   end

endmodule

// ===== test/mandelbrot_escape_test_tb.sv =====
`timescale 1ns / 1ps

module mandelbrot_escape_test_tb;

   localparam int CW  = mbt_pkg::C_W;
   localparam int LW  = mbt_pkg::LIMIT_W;
   localparam int PAD = mbt_pkg::REQ_DATA_W - 2 * CW - LW;
   localparam int ONE = 1 << mbt_pkg::FRAC_BITS;
   localparam int TWO = 2 * ONE;
   localparam logic [LW-1:0] MAX_LIMIT = '1;
   localparam int RANDOM_POINTS = 368;
   localparam int CYCLE_LIMIT   = 10_000_000;
   localparam int DRAIN_CYCLES  = 40;
   // closest fixed-point values below and above sqrt(2)
   localparam int ROOT2_LOW  = 379625062;
   localparam int ROOT2_HIGH = 379625063;

   logic                           clock = 1'b0;
   logic                           reset = 1'b1;
   logic                           req_tvalid = 1'b0;
   logic                           req_tready;
   // c_real [31:0], c_imag [63:32], iteration_limit [80:64], zero pad above
   logic [mbt_pkg::REQ_DATA_W-1:0] req_tdata = '0;
   logic                           rsp_tvalid;
   logic                           rsp_tready = 1'b0;
   // in_set [0], zero pad above
   logic [mbt_pkg::RSP_DATA_W-1:0] rsp_tdata;

   int sender_idle_pct   = 36;
   int receiver_idle_pct = 72;
   int cycle_count       = 0;
   int failures;
   int verdicts_pending;
   int points_checked;
   int inside_count;

   mandelbrot_escape_test i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   mandelbrot_escape_test_checker i_checker (
      .clock            (clock),
      .reset            (reset),
      .req_tvalid       (req_tvalid),
      .req_tready       (req_tready),
      .req_tdata        (req_tdata),
      .rsp_tvalid       (rsp_tvalid),
      .rsp_tready       (rsp_tready),
      .rsp_tdata        (rsp_tdata),
      .failures         (failures),
      .verdicts_pending (verdicts_pending),
      .points_checked   (points_checked),
      .inside_count     (inside_count)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // stall the result channel at random
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= ($urandom_range(99) >= receiver_idle_pct);
      end
   end

   // abort a hung run
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("timeout after %0d cycles, %0d results outstanding",
                  cycle_count, verdicts_pending);
         $display("[FAIL] regression broken");
         $finish;
      end
   end

   // offer one point, idling first at random, and hold it until the transfer
   task automatic send_point(input logic signed [CW-1:0] c_re,
                             input logic signed [CW-1:0] c_im,
                             input logic [LW-1:0]        limit);
      while ($urandom_range(99) < sender_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {{PAD{1'b0}}, limit, c_im, c_re};
      @(posedge clock);
      while (!req_tready)
         @(posedge clock);
   endtask

   // mostly points near the set boundary, some raw noise
   task automatic send_random_point();
      int unsigned             pick;
      logic signed [CW-1:0]    c_re;
      logic signed [CW-1:0]    c_im;
      logic [LW-1:0]           limit;
      pick = $urandom_range(99);
      if (pick < 8) begin
         c_re  = $urandom();
         c_im  = $urandom();
         limit = '0;
      end else if (pick < 30) begin
         c_re  = $urandom();
         c_im  = $urandom();
         limit = LW'($urandom_range(int'(MAX_LIMIT)));
         // keep slow orbits short when c lands near the set
         if (c_re > -TWO && c_re < TWO && c_im > -TWO && c_im < TWO)
            limit = limit & LW'(9'h1FF);
      end else begin
         c_re  = $urandom_range(5 * ONE / 2) - TWO;
         c_im  = $urandom_range(5 * ONE / 2) - 5 * ONE / 4;
         limit = (pick < 40) ? LW'($urandom_range(1500, 65)) : LW'($urandom_range(64, 1));
      end
      send_point(c_re, c_im, limit);
   endtask

   initial begin
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // zero limits and extreme c
      send_point(0, 0, 0);
      send_point(32'h7FFF_FFFF, 32'h8000_0000, 0);
      send_point(32'h8000_0000, 32'h7FFF_FFFF, 1);
      send_point(32'h7FFF_FFFF, 32'h7FFF_FFFF, MAX_LIMIT);
      send_point(32'h8000_0000, 32'h8000_0000, 5);
      // a component landing exactly on 2 or just inside it
      send_point(TWO, 0, 1);
      send_point(-TWO, 0, 3);
      send_point(0, TWO, 2);
      send_point(TWO - 1, 0, 1);
      send_point(TWO - 1, 0, 2);
      send_point(-TWO + 1, 0, 8);
      // squared magnitude just below and just above 4
      send_point(ROOT2_LOW, ROOT2_LOW, 1);
      send_point(ROOT2_HIGH, ROOT2_HIGH, 1);
      // bounded orbits: origin, cusp, period two and three, preperiodic
      send_point(0, 0, 1);
      send_point(0, 0, MAX_LIMIT);
      send_point(ONE / 4, 0, 1536);
      send_point(ONE / 4 + 1, 0, 1536);
      send_point(-ONE, 0, 1536);
      send_point(-7 * ONE / 4, 0, 1536);
      send_point(0, ONE, 300);
      send_point(-3 * ONE / 4, ONE / 10, 1536);
      send_point(-1, -1, 1000);

      // random points over three pacing phases
      for (int k = 0; k < RANDOM_POINTS; k++) begin
         if (k == 110) begin
            sender_idle_pct   = 72;
            receiver_idle_pct = 36;
         end else if (k == 240) begin
            sender_idle_pct   = 0;
            receiver_idle_pct = 0;
         end
         send_random_point();
      end
      req_tvalid <= 1'b0;
      @(posedge clock);

      // drain, then give late results a chance to show up
      while (verdicts_pending != 0)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("%0d points checked: %0d stayed bounded, %0d escaped",
               points_checked, inside_count, points_checked - inside_count);
      $display("covered zero and full-range limits, escape at 2 and at magnitude 4, %s",
               "near-boundary orbits and three pacing mixes");
      if (failures == 0 && verdicts_pending == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end

endmodule

// ===== mandelbrot_escape_test.f =====
+incdir+src
src/mbt_pkg.sv
src/mbt_front.sv
src/mbt_engine.sv
src/mandelbrot_escape_test.sv
test/mandelbrot_escape_test_checker.sv
test/mandelbrot_escape_test_tb.sv
